// ===== rtl/core/qvt_pkg.sv =====
`timescale 1ns / 1ps

package qvt_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam int QUAT_W = 18;
  localparam int PROD_W = 2 * QUAT_W;
  localparam int MAT_W = PROD_W + 2;
  localparam int FRAC_SHIFT = 32;
  localparam int MAT_N = 9;
  localparam int DIM_N = 3;

  localparam int CFG_IDX_W = 3;

  localparam logic signed [QUAT_W-1:0] ROT_W_RESET = 18'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

endpackage

// ===== rtl/core/qvt_coef.sv =====
`timescale 1ns / 1ps

module qvt_coef import qvt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  quat_t                         quat,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vert [DIM_N],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [MAT_W-1:0]       mat [MAT_N],
  output logic signed [COORD_WIDTH-1:0] vert [DIM_N]
);

  logic v1_r, v2_r;
  logic en1, en2;

  logic signed [QUAT_W-1:0] qw, qx, qy, qz;

  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r;
  logic signed [PROD_W-1:0] xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [COORD_WIDTH-1:0] v1_vert_r [DIM_N];

  logic signed [MAT_W-1:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [MAT_W-1:0] mat_nxt [MAT_N];
  logic signed [MAT_W-1:0] mat_r [MAT_N];
  logic signed [COORD_WIDTH-1:0] v2_vert_r [DIM_N];

  assign qw = quat.w;
  assign qx = quat.x;
  assign qy = quat.y;
  assign qz = quat.z;

  assign en2 = !v2_r || out_ready;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      ww_r <= qw * qw;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      xy_r <= qx * qy;
      xz_r <= qx * qz;
      yz_r <= qy * qz;
      wx_r <= qw * qx;
      wy_r <= qw * qy;
      wz_r <= qw * qz;
      for (int k = 0; k < DIM_N; k++) begin
        v1_vert_r[k] <= in_vert[k];
      end
    end
  end

  assign eww = MAT_W'(ww_r);
  assign exx = MAT_W'(xx_r);
  assign eyy = MAT_W'(yy_r);
  assign ezz = MAT_W'(zz_r);
  assign exy = MAT_W'(xy_r);
  assign exz = MAT_W'(xz_r);
  assign eyz = MAT_W'(yz_r);
  assign ewx = MAT_W'(wx_r);
  assign ewy = MAT_W'(wy_r);
  assign ewz = MAT_W'(wz_r);

  always_comb begin
    mat_nxt[0] = eww + exx - eyy - ezz;
    mat_nxt[1] = (exy - ewz) <<< 1;
    mat_nxt[2] = (exz + ewy) <<< 1;
    mat_nxt[3] = (exy + ewz) <<< 1;
    mat_nxt[4] = eww - exx + eyy - ezz;
    mat_nxt[5] = (eyz - ewx) <<< 1;
    mat_nxt[6] = (exz - ewy) <<< 1;
    mat_nxt[7] = (eyz + ewx) <<< 1;
    mat_nxt[8] = eww - exx - eyy + ezz;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      for (int i = 0; i < MAT_N; i++) begin
        mat_r[i] <= mat_nxt[i];
      end
      for (int k = 0; k < DIM_N; k++) begin
        v2_vert_r[k] <= v1_vert_r[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      mat[i] = mat_r[i];
    end
    for (int k = 0; k < DIM_N; k++) begin
      vert[k] = v2_vert_r[k];
    end
  end

endmodule

// ===== rtl/core/qvt_mac.sv =====
`timescale 1ns / 1ps

module qvt_mac import qvt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int ACC_W = MAT_W + COORD_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [MAT_W-1:0]       mat [MAT_N],
  input  logic signed [COORD_WIDTH-1:0] vert [DIM_N],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ACC_W-1:0]       acc [DIM_N]
);

  localparam int VLO_W = COORD_WIDTH / 2;
  localparam int VHI_W = COORD_WIDTH - VLO_W;
  localparam int PL_W = MAT_W + VLO_W + 1;
  localparam int PH_W = MAT_W + VHI_W;
  localparam int TERM_W = MAT_W + COORD_WIDTH;

  logic v3_r, v4_r, v5_r;
  logic en3, en4, en5;

  logic signed [PL_W-1:0]   pl_r [MAT_N];
  logic signed [PH_W-1:0]   ph_r [MAT_N];
  logic signed [TERM_W-1:0] term_r [MAT_N];
  logic signed [ACC_W-1:0]  acc_r [DIM_N];

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign in_ready = en3;
  assign out_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= in_valid;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  // Each coefficient is multiplied by the unsigned low half and the signed
  // high half of its vertex coordinate separately.
  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      for (int r = 0; r < DIM_N; r++) begin
        for (int c = 0; c < DIM_N; c++) begin
          pl_r[r*DIM_N+c] <= mat[r*DIM_N+c] * $signed({1'b0, vert[c][VLO_W-1:0]});
          ph_r[r*DIM_N+c] <= mat[r*DIM_N+c] * $signed(vert[c][COORD_WIDTH-1:VLO_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      for (int i = 0; i < MAT_N; i++) begin
        term_r[i] <= (TERM_W'(ph_r[i]) <<< VLO_W) + TERM_W'(pl_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      for (int r = 0; r < DIM_N; r++) begin
        acc_r[r] <= ACC_W'(term_r[r*DIM_N]) + ACC_W'(term_r[r*DIM_N+1])
                    + ACC_W'(term_r[r*DIM_N+2]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < DIM_N; k++) begin
      acc[k] = acc_r[k];
    end
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v3_r && v4_r && v5_r))
    else $error("multiply stages refuse a transfer while a stage is empty");

  a_stall_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_ready) |=> (v5_r && $stable(acc_r[0]) && $stable(acc_r[1])
                              && $stable(acc_r[2])))
    else $error("row sums changed while the next stage was stalled");

endmodule

// ===== rtl/core/qvt_out.sv =====
`timescale 1ns / 1ps

module qvt_out import qvt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int ACC_W = MAT_W + COORD_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ACC_W-1:0]       acc [DIM_N],
  input  logic signed [COORD_WIDTH-1:0] shift [DIM_N],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] world [DIM_N],
  output logic                          clipped
);

  localparam int RED_W = ACC_W - FRAC_SHIFT;
  localparam int SUM_W = RED_W + 1;
  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic v6_r;
  logic en6;

  logic signed [SUM_W-1:0]       sum [DIM_N];
  logic [DIM_N-1:0]              ovf;
  logic signed [COORD_WIDTH-1:0] world_nxt [DIM_N];
  logic signed [COORD_WIDTH-1:0] world_r [DIM_N];
  logic                          clipped_r;

  assign en6 = !v6_r || out_ready;
  assign in_ready = en6;
  assign out_valid = v6_r;

  // The arithmetic shift floors away the 32 fraction bits of the coefficients
  // before the translation is added; only the final sum saturates.
  always_comb begin
    for (int k = 0; k < DIM_N; k++) begin
      sum[k] = SUM_W'($signed(acc[k][ACC_W-1:FRAC_SHIFT])) + SUM_W'(shift[k]);
      ovf[k] = !(&sum[k][SUM_W-1:COORD_WIDTH-1]) && (|sum[k][SUM_W-1:COORD_WIDTH-1]);
      if (ovf[k]) begin
        world_nxt[k] = sum[k][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        world_nxt[k] = sum[k][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en6 && in_valid) begin
      for (int k = 0; k < DIM_N; k++) begin
        world_r[k] <= world_nxt[k];
      end
      clipped_r <= |ovf;
    end
  end

  always_comb begin
    for (int k = 0; k < DIM_N; k++) begin
      world[k] = world_r[k];
    end
  end
  assign clipped = clipped_r;

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && clipped_r) |->
      (world_r[0] == SAT_MAX || world_r[0] == SAT_MIN ||
       world_r[1] == SAT_MAX || world_r[1] == SAT_MIN ||
       world_r[2] == SAT_MAX || world_r[2] == SAT_MIN))
    else $error("clip flag set but no coordinate sits at a limit");

  a_capture_only_on_space: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && !out_ready) |=> (v6_r && $stable(world_r[0]) && $stable(world_r[1])
                              && $stable(world_r[2]) && $stable(clipped_r)))
    else $error("output register overwritten while the result waited");

endmodule

// ===== rtl/core/quaternion_vertex_transform.sv =====
`timescale 1ns / 1ps

// Rotates each vertex by the configured quaternion as q*(0,v)*conj(q), with
// no normalisation, floors the result to the fraction format of the vertex
// coordinates, adds the translation and saturates to COORD_WIDTH bits,
// raising clipped when any coordinate saturates. The block takes one vertex
// per clock while the output is not stalled and gives one result per vertex:
// two stages form the rotation matrix from the quaternion, three stages
// multiply and sum the rows with each coordinate split into two halves, and
// the last stage translates, saturates and holds the result. Each stage takes
// a new item as soon as its contents move on, so a stall only fills empty
// stages. Registers are to be written only with no vertex in flight, which
// the block does not enforce; after reset the transform is the identity.

module quaternion_vertex_transform import qvt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int CFG_W = (COORD_WIDTH > QUAT_W) ? COORD_WIDTH : QUAT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vert_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_world_x,
  output logic signed [COORD_WIDTH-1:0] out_world_y,
  output logic signed [COORD_WIDTH-1:0] out_world_z,
  output logic                          out_clipped
);

  localparam int ACC_W = MAT_W + COORD_WIDTH + 2;

  logic signed [QUAT_W-1:0]      rot_w_r, rot_x_r, rot_y_r, rot_z_r;
  logic signed [COORD_WIDTH-1:0] shift_x_r, shift_y_r, shift_z_r;

  quat_t                         quat;
  logic signed [COORD_WIDTH-1:0] in_vert [DIM_N];
  logic signed [COORD_WIDTH-1:0] shift [DIM_N];

  logic                          coef_valid, coef_ready;
  logic signed [MAT_W-1:0]       mat [MAT_N];
  logic signed [COORD_WIDTH-1:0] coef_vert [DIM_N];

  logic                          mac_valid, mac_ready;
  logic signed [ACC_W-1:0]       acc [DIM_N];

  logic signed [COORD_WIDTH-1:0] world [DIM_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r   <= ROT_W_RESET;
      rot_x_r   <= '0;
      rot_y_r   <= '0;
      rot_z_r   <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROT_W:   rot_w_r   <= cfg_wdata[QUAT_W-1:0];
        REG_ROT_X:   rot_x_r   <= cfg_wdata[QUAT_W-1:0];
        REG_ROT_Y:   rot_y_r   <= cfg_wdata[QUAT_W-1:0];
        REG_ROT_Z:   rot_z_r   <= cfg_wdata[QUAT_W-1:0];
        REG_SHIFT_X: shift_x_r <= cfg_wdata[COORD_WIDTH-1:0];
        REG_SHIFT_Y: shift_y_r <= cfg_wdata[COORD_WIDTH-1:0];
        REG_SHIFT_Z: shift_z_r <= cfg_wdata[COORD_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign quat.w = rot_w_r;
  assign quat.x = rot_x_r;
  assign quat.y = rot_y_r;
  assign quat.z = rot_z_r;

  assign in_vert[0] = in_vert_x;
  assign in_vert[1] = in_vert_y;
  assign in_vert[2] = in_vert_z;

  assign shift[0] = shift_x_r;
  assign shift[1] = shift_y_r;
  assign shift[2] = shift_z_r;

  qvt_coef #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .quat      (quat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_vert   (in_vert),
    .out_valid (coef_valid),
    .out_ready (coef_ready),
    .mat       (mat),
    .vert      (coef_vert)
  );

  qvt_mac #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .mat       (mat),
    .vert      (coef_vert),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .acc       (acc)
  );

  qvt_out #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mac_valid),
    .in_ready  (mac_ready),
    .acc       (acc),
    .shift     (shift),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .world     (world),
    .clipped   (out_clipped)
  );

  assign out_world_x = world[0];
  assign out_world_y = world[1];
  assign out_world_z = world[2];

endmodule
